### hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition at one edge implies a consequence at the next edge.
`define PTS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

### hdl/pts_pkg.sv
// Types and command codes for the periodic task scheduler.
// No dependencies; imported by the scheduler top level.
`default_nettype none
package pts_pkg;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_ENABLE   = 3'd1;
    localparam logic [2:0] CMD_DISABLE  = 3'd2;
    localparam logic [2:0] CMD_REQUEST  = 3'd3;
    localparam logic [2:0] CMD_TICK     = 3'd4;
    localparam logic [2:0] CMD_DISPATCH = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  slot;
        logic [15:0] period_ticks;
    } t_cmd;

    typedef struct packed {
        logic       success;
        logic [3:0] chosen_slot;
    } t_result;

endpackage
`default_nettype wire

### hdl/pts_tick_unit.sv
// Shared countdown unit: decrements one slot's countdown, detects expiry
// and selects the reload value. Depends on nothing but its parameter.
`default_nettype none
module pts_tick_unit #(
    parameter int PERIOD_BITS = 16
) (
    input  wire logic                   i_live,
    input  wire logic [PERIOD_BITS-1:0] i_count,
    input  wire logic [PERIOD_BITS-1:0] i_reload,
    output logic                        o_update,
    output logic                        o_fire,
    output logic [PERIOD_BITS-1:0]      o_next
);
    logic [PERIOD_BITS-1:0] w_dec;

    always_comb begin
        w_dec    = i_count - PERIOD_BITS'(1);
        o_update = i_live && (i_count != '0);
        o_fire   = o_update && (w_dec == '0);
        // reload on expiry
        o_next   = o_fire ? i_reload : w_dec;
    end
endmodule
`default_nettype wire

### hdl/periodic_task_scheduler_top.sv
// Top level of the periodic task scheduler: sequencer, slot table and the
// shared countdown unit. Depends on pts_pkg, pts_tick_unit, assert_macros.svh.
//
// Usage:
//   Drive i_cmd and raise start while busy is low; the word is taken at that
//   clock edge and busy rises on the next cycle. Exactly one result word is
//   shown on o_result for one cycle, marked by o_done; the receiver cannot
//   hold it off and must take it in that cycle.
//   Add, enable, disable, request and the unused codes finish in the execute
//   state, which raises o_done. Tick walks every slot through the one shared
//   countdown unit, one slot per cycle. Dispatch walks slots from slot 0 and
//   stops at the first runnable one, or at the last slot if none is runnable.
//   The slot walk sets the rate; busy falls in the cycle o_done is high, so a
//   new word may be taken then.
//   Reset clears all slot flags, the sequencer and the result strobe; the
//   countdown and period registers are loaded by add before any use.
`default_nettype none
module periodic_task_scheduler_top #(
    parameter int TASK_COUNT  = 8,
    parameter int PERIOD_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire pts_pkg::t_cmd    i_cmd,
    output logic                  busy,
    output logic                  o_done,
    output pts_pkg::t_result      o_result
);
    import pts_pkg::*;

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);
    localparam logic [4:0] SLOT_LIMIT = 5'(TASK_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SCAN = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [TASK_COUNT-1:0]   r_valid, n_valid;
    logic [TASK_COUNT-1:0]   r_enabled, n_enabled;
    logic [TASK_COUNT-1:0]   r_ready, n_ready;
    logic                    r_done, n_done;
    t_result                 r_result, n_result;

    logic [PERIOD_BITS-1:0]  r_count [TASK_COUNT];
    logic [PERIOD_BITS-1:0]  r_period [TASK_COUNT];

    logic                    w_in_range;
    logic [IDX_W-1:0]        w_slot_idx;
    logic [PERIOD_BITS-1:0]  w_period;
    logic                    w_cnt_we;
    logic [IDX_W-1:0]        w_cnt_addr;
    logic [PERIOD_BITS-1:0]  w_cnt_wdata;
    logic                    w_per_we;
    logic                    w_live;
    logic                    w_update;
    logic                    w_fire;
    logic [PERIOD_BITS-1:0]  w_next;

    assign w_in_range = ({1'b0, r_cmd.slot} < SLOT_LIMIT);
    assign w_slot_idx = r_cmd.slot[IDX_W-1:0];
    assign w_period   = PERIOD_BITS'(r_cmd.period_ticks);
    assign w_live     = r_valid[r_idx] && r_enabled[r_idx];

    pts_tick_unit #(
        .PERIOD_BITS(PERIOD_BITS)
    ) u_tick (
        .i_live   (w_live),
        .i_count  (r_count[r_idx]),
        .i_reload (r_period[r_idx]),
        .o_update (w_update),
        .o_fire   (w_fire),
        .o_next   (w_next)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_enabled   = r_enabled;
        n_ready     = r_ready;
        n_done      = 1'b0;
        n_result    = r_result;
        w_cnt_we    = 1'b0;
        w_cnt_addr  = r_idx;
        w_cnt_wdata = w_next;
        w_per_we    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_result = '0;
                n_done   = 1'b1;
                n_state  = ST_IDLE;
                unique case (r_cmd.command)
                    CMD_ADD: begin
                        if (w_in_range && !r_valid[w_slot_idx]) begin
                            n_valid[w_slot_idx]   = 1'b1;
                            n_enabled[w_slot_idx] = 1'b1;
                            n_ready[w_slot_idx]   = 1'b0;
                            w_cnt_we              = 1'b1;
                            w_cnt_addr            = w_slot_idx;
                            w_cnt_wdata           = w_period;
                            w_per_we              = 1'b1;
                            n_result.success      = 1'b1;
                        end
                    end
                    CMD_ENABLE: begin
                        if (w_in_range) n_enabled[w_slot_idx] = 1'b1;
                    end
                    CMD_DISABLE: begin
                        if (w_in_range) n_enabled[w_slot_idx] = 1'b0;
                    end
                    CMD_REQUEST: begin
                        if (w_in_range) n_ready[w_slot_idx] = 1'b1;
                    end
                    CMD_TICK, CMD_DISPATCH: begin
                        // hold the result until the slot walk ends
                        n_done  = 1'b0;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                if (r_cmd.command == CMD_TICK) begin
                    if (w_update) begin
                        w_cnt_we = 1'b1;
                        if (w_fire) n_ready[r_idx] = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    // dispatch: stop at the first runnable slot
                    priority if (w_live && r_ready[r_idx]) begin
                        n_ready[r_idx]       = 1'b0;
                        n_result.success     = 1'b1;
                        n_result.chosen_slot = 4'(r_idx);
                        n_done               = 1'b1;
                        n_state              = ST_IDLE;
                    end else if (r_idx == LAST_IDX) begin
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_valid   <= '0;
            r_enabled <= '0;
            r_ready   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_valid   <= n_valid;
            r_enabled <= n_enabled;
            r_ready   <= n_ready;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_result <= n_result;
        if (w_cnt_we) r_count[w_cnt_addr] <= w_cnt_wdata;
        if (w_per_we) r_period[w_slot_idx] <= w_period;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

`include "assert_macros.svh"

    `PTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `PTS_ASSERT(a_done_after_work, !o_done || $past(busy), "result strobe without work")
    `PTS_ASSERT(a_fail_slot_zero, !(o_done && !o_result.success) || (o_result.chosen_slot == 4'd0), "failed result carries a slot")
    `PTS_ASSERT_NEXT(a_valid_sticky, 1'b1, (r_valid & $past(r_valid)) == $past(r_valid), "occupied slot was freed")

endmodule
`default_nettype wire

### tb/periodic_task_scheduler_top_tb.sv
// Self-checking testbench for periodic_task_scheduler_top: directed and random command words,
// predicted by a scoreboard class. Depends on pts_pkg and the scheduler RTL only.
`default_nettype none
module periodic_task_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int TASK_COUNT = 8;
    localparam int RANDOM_WORDS = 1900;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    class sched_scoreboard;
        bit          slot_valid[TASK_COUNT];
        bit          slot_enabled[TASK_COUNT];
        bit          slot_ready[TASK_COUNT];
        logic [15:0] countdown[TASK_COUNT];
        logic [15:0] reload_period[TASK_COUNT];
        t_result     pending_q[$];
        int          errors;
        int          words_in;
        int          results_seen;
        int          dispatch_hits;

        function new();
            for (int i = 0; i < TASK_COUNT; i++) begin
                slot_valid[i] = 0;
                slot_enabled[i] = 0;
                slot_ready[i] = 0;
                countdown[i] = '0;
                reload_period[i] = '0;
            end
            errors = 0;
            words_in = 0;
            results_seen = 0;
            dispatch_hits = 0;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        // Update the slot table for an accepted command word and queue its answer.
        function void note_cmd(t_cmd c);
            t_result r;
            int      idx;
            bit      in_range;
            bit      found;
            r = '0;
            idx = int'(c.slot);
            in_range = idx < TASK_COUNT;
            found = 0;
            words_in++;
            case (c.command)
                CMD_ADD: begin
                    if (in_range && !slot_valid[idx]) begin
                        slot_valid[idx] = 1;
                        slot_ready[idx] = 0;
                        slot_enabled[idx] = 1;
                        countdown[idx] = c.period_ticks;
                        reload_period[idx] = c.period_ticks;
                        r.success = 1'b1;
                    end
                end
                CMD_ENABLE: if (in_range) slot_enabled[idx] = 1;
                CMD_DISABLE: if (in_range) slot_enabled[idx] = 0;
                CMD_REQUEST: if (in_range) slot_ready[idx] = 1;
                CMD_TICK: begin
                    for (int i = 0; i < TASK_COUNT; i++) begin
                        if (slot_valid[i] && slot_enabled[i] && countdown[i] != '0) begin
                            countdown[i] = countdown[i] - 16'd1;
                            if (countdown[i] == '0) begin
                                slot_ready[i] = 1;
                                countdown[i] = reload_period[i];
                            end
                        end
                    end
                end
                CMD_DISPATCH: begin
                    // lowest runnable slot wins
                    for (int i = 0; i < TASK_COUNT; i++) begin
                        if (!found && slot_valid[i] && slot_enabled[i] && slot_ready[i]) begin
                            found = 1;
                            slot_ready[i] = 0;
                            r.success = 1'b1;
                            r.chosen_slot = 4'(i);
                        end
                    end
                    if (found) dispatch_hits++;
                end
                default: ;
            endcase
            pending_q.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result want;
            results_seen++;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending: %p", got));
            end else begin
                want = pending_q.pop_front();
                if (got.success !== want.success)
                    report_mismatch($sformatf("success got %b want %b",
                                              got.success, want.success));
                if (got.chosen_slot !== want.chosen_slot)
                    report_mismatch($sformatf("chosen_slot got %0d want %0d",
                                              got.chosen_slot, want.chosen_slot));
            end
        endtask
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_done;
    t_result o_result;

    sched_scoreboard sb;
    int unsigned     cycles;

    periodic_task_scheduler_top #(
        .TASK_COUNT (TASK_COUNT),
        .PERIOD_BITS(16)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        sb = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // Hold start high from a falling edge until a rising edge sees busy low.
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.note_cmd(c);
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [3:0] slot,
                         input logic [15:0] period);
        t_cmd c;
        c.command = cmd;
        c.slot = slot;
        c.period_ticks = period;
        send_cmd(c);
    endtask

    task automatic random_cmd();
        t_cmd        c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 7) c.command = CMD_ADD;
        else if (pick < 15) c.command = CMD_ENABLE;
        else if (pick < 23) c.command = CMD_DISABLE;
        else if (pick < 33) c.command = CMD_REQUEST;
        else if (pick < 66) c.command = CMD_TICK;
        else if (pick < 97) c.command = CMD_DISPATCH;
        else c.command = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        if ($urandom_range(0, 99) < 85) c.slot = 4'($urandom_range(0, TASK_COUNT - 1));
        else c.slot = 4'($urandom_range(0, 15));
        // keep most periods short so slots actually come due
        if (c.command == CMD_ADD && $urandom_range(0, 99) < 80)
            c.period_ticks = 16'($urandom_range(0, 6));
        else
            c.period_ticks = 16'($urandom);
        send_cmd(c);
    endtask

    initial begin
        cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, out of range, refusals, zero and full periods
        issue(CMD_DISPATCH, 4'd0, 16'h0000);
        issue(CMD_ENABLE, 4'd3, 16'hFFFF);
        issue(CMD_REQUEST, 4'd3, 16'h0000);
        issue(CMD_DISPATCH, 4'd0, 16'hFFFF);
        issue(CMD_ADD, 4'd3, 16'd2);
        issue(CMD_ADD, 4'd3, 16'd5);
        issue(CMD_ADD, 4'd15, 16'd1);
        issue(CMD_ADD, 4'd8, 16'd1);
        issue(CMD_ENABLE, 4'd8, 16'd0);
        issue(CMD_DISABLE, 4'd15, 16'd0);
        issue(CMD_REQUEST, 4'd15, 16'd0);
        issue(CMD_ADD, 4'd0, 16'd0);
        issue(CMD_TICK, 4'd0, 16'd0);
        issue(CMD_REQUEST, 4'd0, 16'd0);
        issue(CMD_ADD, 4'd7, 16'hFFFF);
        issue(CMD_TICK, 4'd15, 16'hFFFF);
        issue(CMD_DISPATCH, 4'd0, 16'd0);
        issue(CMD_DISPATCH, 4'd0, 16'd0);
        issue(CMD_DISABLE, 4'd3, 16'd0);
        issue(CMD_REQUEST, 4'd3, 16'd0);
        issue(CMD_DISPATCH, 4'd15, 16'd0);
        issue(CMD_ENABLE, 4'd3, 16'd0);
        issue(CMD_DISPATCH, 4'd0, 16'd0);
        issue(CMD_SPARE_LO, 4'd3, 16'hA5A5);
        issue(CMD_SPARE_HI, 4'd12, 16'h5A5A);

        repeat (RANDOM_WORDS) random_cmd();

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (TASK_COUNT + 4) @(posedge i_clk);

        if (sb.pending_q.size() != 0)
            sb.report_mismatch($sformatf("%0d result words never arrived",
                                         sb.pending_q.size()));
        $display("Sent %0d command words, checked %0d result words, %0d dispatches found work",
                 sb.words_in, sb.results_seen, sb.dispatch_hits);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/pts_pkg.sv
hdl/pts_tick_unit.sv
hdl/periodic_task_scheduler_top.sv
tb/periodic_task_scheduler_top_tb.sv
